FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define CHK_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed: same-cycle implication");

// next-cycle implication, quiet during reset
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: next-cycle implication");

`endif

FILE: hw/rtl/pie_pkg.sv
// types, codes and helpers for the power iteration eigen block
package pie_pkg;

   localparam int MAX_DIM_DEFAULT = 16;

   localparam logic [1:0] CMD_LOAD_MATRIX = 2'd0;
   localparam logic [1:0] CMD_LOAD_VECTOR = 2'd1;
   localparam logic [1:0] CMD_START       = 2'd2;

   localparam logic [1:0] CSR_DIMENSION       = 2'd0;
   localparam logic [1:0] CSR_TOLERANCE       = 2'd1;
   localparam logic [1:0] CSR_ITERATION_LIMIT = 2'd2;

   localparam logic [4:0]  DIMENSION_RESET       = 5'd4;
   localparam logic [15:0] TOLERANCE_RESET       = 16'd1;
   localparam logic [15:0] ITERATION_LIMIT_RESET = 16'd1000;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [3:0]         row;
      logic [3:0]         col;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [3:0]         index;
      logic signed [31:0] component;
      logic signed [31:0] eigenvalue;
      logic [15:0]        passes;
      logic               converged;
      logic               last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PASS,
      ST_MREAD,
      ST_MMUL,
      ST_MACC,
      ST_DREAD,
      ST_DLOAD,
      ST_DIVIDE,
      ST_DWRITE,
      ST_SREAD,
      ST_SACC,
      ST_CHECK,
      ST_CREAD,
      ST_CWRITE,
      ST_OREAD,
      ST_OUT
   } state_type;

   // clamp a wide signed value to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // magnitude of a signed 32-bit value as unsigned 32 bits
   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      logic [31:0] r;
      r = v[31] ? (~v + 32'd1) : v;
      return r;
   endfunction

endpackage

FILE: hw/rtl/power_iteration_eigen.sv
// top level of the power iteration dominant eigenvalue block
//
//  channel | direction | handshake           | word
//  req     | in        | req_valid/req_ready | req_type: cmd, row, col, value
//  rsp     | out       | rsp_valid/rsp_ready | rsp_type: index .. last
//  csr     | in        | csr_valid/csr_ready | csr_index, csr_data (16 bits)
//
// load words are taken while idle; a start word holds req_ready low for the run
// the 48-step divider is shared by all components of a pass; the matrix walk
// steps through memory read, multiply and add states for each product
// each result word is built from a vector read, rsp stalls hold it
// reset is synchronous: clears control and configuration, stores keep contents
module power_iteration_eigen #(
   parameter int MAX_DIM = pie_pkg::MAX_DIM_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pie_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pie_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_data
);
   import pie_pkg::*;

   localparam int AW        = $clog2(MAX_DIM);
   localparam int CW        = $clog2(MAX_DIM + 1);
   localparam int MAT_DEPTH = MAX_DIM * MAX_DIM;
   localparam int MAT_AW    = $clog2(MAT_DEPTH);
   localparam int ACC_W     = 48 + $clog2(MAX_DIM) + 1;
   localparam int DIFF_W    = 34 + $clog2(MAX_DIM);

   // configuration registers
   logic [4:0]  dim_ff, dim_in;
   logic [15:0] tol_ff, tol_in;
   logic [15:0] lim_ff, lim_in;

   // sequencer state
   state_type          state_ff, state_in;
   logic [AW-1:0]      i_ff, i_in;
   logic [AW-1:0]      j_ff, j_in;
   logic [CW-1:0]      d_ff, d_in;
   logic [15:0]        iters_ff, iters_in;
   logic               conv_ff, conv_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [63:0]       prod_ff, prod_in;
   logic [31:0]              best_ff, best_in;
   logic signed [31:0]       eig_ff, eig_in;
   logic [DIFF_W-1:0]        diff_ff, diff_in;
   logic [31:0]              rem_ff, rem_in;
   logic [47:0]              dvd_ff, dvd_in;
   logic [47:0]              quo_ff, quo_in;
   logic [5:0]               bit_ff, bit_in;
   logic                     dsign_ff, dsign_in;
   rsp_type                  rsp_ff, rsp_in;

   // stores
   logic signed [31:0] mat_mem [MAT_DEPTH];
   logic signed [31:0] vec_mem [MAX_DIM];
   logic signed [31:0] prd_mem [MAX_DIM];
   logic signed [31:0] mat_rd_ff, vec_rd_ff, prd_rd_ff;

   logic              mat_we;
   logic [MAT_AW-1:0] mat_wa, mat_ra;
   logic              vec_we;
   logic [AW-1:0]     vec_wa, vec_ra;
   logic signed [31:0] vec_wd;
   logic              prd_we;
   logic [AW-1:0]     prd_wa, prd_ra;
   logic signed [31:0] prd_wd;

   // helpers
   logic [CW-1:0]         d_m1;
   logic                  i_last, j_last;
   logic [CW-1:0]         d_clamp;
   logic signed [ACC_W-1:0] acc_sum;
   logic signed [31:0]    row_sat;
   logic [31:0]           row_mag;
   logic [32:0]           rem_shift;
   logic [31:0]           div_mag;
   logic signed [48:0]    quo_signed;
   logic signed [32:0]    delta;
   logic [32:0]           delta_mag;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign d_m1   = d_ff - 1'b1;
   assign i_last = (i_ff == AW'(d_m1));
   assign j_last = (j_ff == AW'(d_m1));

   // dimension 0 runs as 1, above the store size runs as the store size
   always_comb begin
      if (dim_ff == 5'd0) begin
         d_clamp = CW'(1);
      end else if (int'(dim_ff) > MAX_DIM) begin
         d_clamp = CW'(MAX_DIM);
      end else begin
         d_clamp = CW'(dim_ff);
      end
   end

   // floor to Q16.16 is an arithmetic shift of the exact product
   assign acc_sum = acc_ff + ACC_W'(prod_ff >>> 16);
   assign row_sat = sat32({{(64 - ACC_W){acc_sum[ACC_W-1]}}, acc_sum});
   assign row_mag = mag32(row_sat);

   // one restoring step per cycle on magnitudes
   assign div_mag   = mag32(eig_ff);
   assign rem_shift = {rem_ff, dvd_ff[47]};
   assign quo_signed = dsign_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

   assign delta     = $signed({prd_rd_ff[31], prd_rd_ff}) - $signed({vec_rd_ff[31], vec_rd_ff});
   assign delta_mag = delta[32] ? (~delta + 33'd1) : delta;

   // configuration writes
   always_comb begin
      dim_in = dim_ff;
      tol_in = tol_ff;
      lim_in = lim_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DIMENSION:       dim_in = csr_data[4:0];
            CSR_TOLERANCE:       tol_in = csr_data;
            CSR_ITERATION_LIMIT: lim_in = csr_data;
            default:             ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= DIMENSION_RESET;
         tol_ff <= TOLERANCE_RESET;
         lim_ff <= ITERATION_LIMIT_RESET;
      end else begin
         dim_ff <= dim_in;
         tol_ff <= tol_in;
         lim_ff <= lim_in;
      end
   end

   // sequencer: next state, store ports and datapath updates
   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      d_in         = d_ff;
      iters_in     = iters_ff;
      conv_in      = conv_ff;
      rsp_valid_in = rsp_valid_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      best_in      = best_ff;
      eig_in       = eig_ff;
      diff_in      = diff_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      quo_in       = quo_ff;
      bit_in       = bit_ff;
      dsign_in     = dsign_ff;
      rsp_in       = rsp_ff;

      mat_we = 1'b0;
      mat_wa = MAT_AW'(int'(req_data.row) * MAX_DIM + int'(req_data.col));
      mat_ra = MAT_AW'(int'(i_ff) * MAX_DIM + int'(j_ff));
      vec_we = 1'b0;
      vec_wa = i_ff;
      vec_wd = prd_rd_ff;
      vec_ra = i_ff;
      prd_we = 1'b0;
      prd_wa = i_ff;
      prd_wd = row_sat;
      prd_ra = i_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_data.cmd)
                  CMD_LOAD_MATRIX: begin
                     mat_we = (int'(req_data.row) < MAX_DIM) &&
                              (int'(req_data.col) < MAX_DIM);
                  end
                  CMD_LOAD_VECTOR: begin
                     vec_we = (int'(req_data.row) < MAX_DIM);
                     vec_wa = AW'(req_data.row);
                     vec_wd = req_data.value;
                  end
                  CMD_START: begin
                     i_in     = '0;
                     j_in     = '0;
                     d_in     = d_clamp;
                     iters_in = '0;
                     conv_in  = 1'b0;
                     eig_in   = '0;
                     state_in = ST_PASS;
                  end
                  default: ;
               endcase
            end
         end
         ST_PASS: begin
            i_in = '0;
            j_in = '0;
            if (iters_ff < lim_ff) begin
               acc_in   = '0;
               best_in  = '0;
               eig_in   = '0;
               diff_in  = '0;
               state_in = ST_MREAD;
            end else begin
               state_in = ST_OREAD;
            end
         end
         ST_MREAD: begin
            vec_ra   = j_ff;
            state_in = ST_MMUL;
         end
         ST_MMUL: begin
            prod_in  = mat_rd_ff * vec_rd_ff;
            state_in = ST_MACC;
         end
         ST_MACC: begin
            if (j_last) begin
               // row done: store it and track the largest magnitude
               prd_we = 1'b1;
               acc_in = '0;
               j_in   = '0;
               if (row_mag > best_ff) begin
                  best_in = row_mag;
                  eig_in  = row_sat;
               end
               if (i_last) begin
                  i_in = '0;
                  if ((row_mag > best_ff ? row_sat : eig_ff) != 32'sd0) begin
                     state_in = ST_DREAD;
                  end else begin
                     state_in = ST_SREAD;
                  end
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_MREAD;
               end
            end else begin
               acc_in   = acc_sum;
               j_in     = j_ff + 1'b1;
               state_in = ST_MREAD;
            end
         end
         ST_DREAD: begin
            state_in = ST_DLOAD;
         end
         ST_DLOAD: begin
            dvd_in   = {mag32(prd_rd_ff), 16'd0};
            rem_in   = '0;
            quo_in   = '0;
            bit_in   = '0;
            dsign_in = prd_rd_ff[31] ^ eig_ff[31];
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            dvd_in = {dvd_ff[46:0], 1'b0};
            if (rem_shift >= {1'b0, div_mag}) begin
               rem_in = 32'(rem_shift - {1'b0, div_mag});
               quo_in = {quo_ff[46:0], 1'b1};
            end else begin
               rem_in = rem_shift[31:0];
               quo_in = {quo_ff[46:0], 1'b0};
            end
            bit_in = bit_ff + 1'b1;
            if (bit_ff == 6'd47) begin
               state_in = ST_DWRITE;
            end
         end
         ST_DWRITE: begin
            prd_we = 1'b1;
            prd_wd = sat32(64'(quo_signed));
            if (i_last) begin
               i_in     = '0;
               state_in = ST_SREAD;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_DREAD;
            end
         end
         ST_SREAD: begin
            state_in = ST_SACC;
         end
         ST_SACC: begin
            diff_in = diff_ff + DIFF_W'(delta_mag);
            if (i_last) begin
               i_in     = '0;
               state_in = ST_CHECK;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_SREAD;
            end
         end
         ST_CHECK: begin
            if (diff_ff < DIFF_W'(tol_ff)) begin
               conv_in  = 1'b1;
               state_in = ST_OREAD;
            end else begin
               state_in = ST_CREAD;
            end
         end
         ST_CREAD: begin
            state_in = ST_CWRITE;
         end
         ST_CWRITE: begin
            vec_we = 1'b1;
            if (i_last) begin
               i_in     = '0;
               iters_in = iters_ff + 16'd1;
               state_in = ST_PASS;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_CREAD;
            end
         end
         ST_OREAD: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff) begin
               // build the result word from the vector read
               rsp_in.index      = 4'(i_ff);
               rsp_in.component  = vec_rd_ff;
               rsp_in.eigenvalue = i_last ? eig_ff : 32'sd0;
               rsp_in.passes     = i_last ? iters_ff : 16'd0;
               rsp_in.converged  = i_last && conv_ff;
               rsp_in.last       = i_last;
               rsp_valid_in      = 1'b1;
            end else if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (i_last) begin
                  state_in = ST_IDLE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_OREAD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         d_ff         <= '0;
         iters_ff     <= '0;
         conv_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         d_ff         <= d_in;
         iters_ff     <= iters_in;
         conv_ff      <= conv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      best_ff  <= best_in;
      eig_ff   <= eig_in;
      diff_ff  <= diff_in;
      rem_ff   <= rem_in;
      dvd_ff   <= dvd_in;
      quo_ff   <= quo_in;
      bit_ff   <= bit_in;
      dsign_ff <= dsign_in;
      rsp_ff   <= rsp_in;
   end

   // stores: one write and one registered read each per cycle
   always_ff @(posedge clock) begin
      if (mat_we) begin
         mat_mem[mat_wa] <= req_data.value;
      end
      mat_rd_ff <= mat_mem[mat_ra];
   end

   always_ff @(posedge clock) begin
      if (vec_we) begin
         vec_mem[vec_wa] <= vec_wd;
      end
      vec_rd_ff <= vec_mem[vec_ra];
   end

   always_ff @(posedge clock) begin
      if (prd_we) begin
         prd_mem[prd_wa] <= prd_wd;
      end
      prd_rd_ff <= prd_mem[prd_ra];
   end

endmodule

FILE: hw/rtl/pie_checker.sv
// port-level checks for the power iteration eigen block, bound to the top level
`include "assert_macros.svh"

module pie_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input pie_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input pie_pkg::rsp_type rsp_data
);
   import pie_pkg::*;

   // no new word is taken while a result waits
   `CHK_SAME(busy_while_rsp, clock, reset, rsp_valid, !req_ready)

   // a start word closes the input for the run
   `CHK_NEXT(start_blocks, clock, reset, req_valid && req_ready && req_data.cmd == CMD_START, !req_ready)

   // summary fields are zero except on the final word
   `CHK_SAME(summary_on_last, clock, reset, rsp_valid && !rsp_data.last, rsp_data.eigenvalue == 32'sd0 && rsp_data.passes == 16'd0 && !rsp_data.converged)

   // a finished result leaves the output register after acceptance
   `CHK_NEXT(rsp_drops, clock, reset, rsp_valid && rsp_ready, !rsp_valid)

endmodule

bind power_iteration_eigen pie_checker u_pie_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

FILE: bench/tb_power_iteration_eigen.sv
// testbench for the power iteration eigen block: directed and random runs with a scoreboard
module tb_power_iteration_eigen;
   import pie_pkg::*;

   localparam int DIM_MAX        = 16;
   localparam int SETTLE_CYCLES  = 40;      // drain time before a csr write
   localparam int WATCHDOG_LIMIT = 200000;  // idle cycles before giving up
   localparam int HOLD_CYCLES    = 2000;    // long receiver hold-off, outlasts a run
   localparam int ITEM_TARGET    = 470;

   // codes the package leaves unnamed
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

   typedef enum int {FILL_SMALL, FILL_FULL, FILL_ZERO} fill_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   power_iteration_eigen #(.MAX_DIM(DIM_MAX)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #6 clock = ~clock;

   // shadow copy of the block: stores, written marks and registers
   logic signed [31:0] matrix_mem [DIM_MAX*DIM_MAX];
   logic signed [31:0] vector_mem [DIM_MAX];
   bit                 matrix_set [DIM_MAX*DIM_MAX];
   bit                 vector_set [DIM_MAX];
   logic [4:0]         cfg_dimension = DIMENSION_RESET;
   logic [15:0]        cfg_tolerance = TOLERANCE_RESET;
   logic [15:0]        cfg_limit     = ITERATION_LIMIT_RESET;

   rsp_type pending_components [$];   // component words still to come, oldest first
   int      error_count = 0;
   int      items_sent  = 0;
   int      idle_cycles = 0;
   bit      quiet       = 1'b0;       // no sender or receiver gaps while set
   bit      hold_req    = 1'b0;       // asks the receiver for one long hold-off

   // dimension as the block uses it: 0 acts as 1, above the store size clamps
   function automatic int eff_dim();
      int d;
      d = int'(cfg_dimension);
      if (d < 1) d = 1;
      if (d > DIM_MAX) d = DIM_MAX;
      return d;
   endfunction

   function automatic logic signed [31:0] clamp_word(longint v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) r = 32'sh7fff_ffff;
      else if (v < -64'sd2147483648) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic longint abs_long(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // full power iteration run on the shadow stores, pushes one word per component
   function automatic void run_power_iteration();
      int                 d;
      int                 passes;
      bit                 conv;
      longint             acc, best, diff, a;
      logic signed [31:0] m, eig;
      logic signed [31:0] prod [DIM_MAX];
      rsp_type            w;
      d = eff_dim();
      passes = 0;
      conv = 1'b0;
      eig = 0;
      while (passes < cfg_limit) begin
         // matrix times vector, each product floored to q16.16
         for (int i = 0; i < d; i++) begin
            acc = 0;
            for (int j = 0; j < d; j++)
               acc += (longint'(matrix_mem[i*DIM_MAX+j]) * longint'(vector_mem[j])) >>> 16;
            prod[i] = clamp_word(acc);
         end
         // largest magnitude with its sign, lowest index wins ties
         m = 0;
         best = 0;
         for (int i = 0; i < d; i++) begin
            a = abs_long(longint'(prod[i]));
            if (a > best) begin
               best = a;
               m = prod[i];
            end
         end
         eig = m;
         if (m != 0) begin
            for (int i = 0; i < d; i++)
               prod[i] = clamp_word((longint'(prod[i]) * 65536) / longint'(m));
         end
         diff = 0;
         for (int i = 0; i < d; i++)
            diff += abs_long(longint'(prod[i]) - longint'(vector_mem[i]));
         if (diff < longint'(cfg_tolerance)) begin
            conv = 1'b1;
            break;
         end
         for (int i = 0; i < d; i++) vector_mem[i] = prod[i];
         passes++;
      end
      for (int i = 0; i < d; i++) begin
         w = '0;
         w.index = i[3:0];
         w.component = vector_mem[i];
         if (i == d - 1) begin
            w.eigenvalue = eig;
            w.passes = passes[15:0];
            w.converged = conv;
            w.last = 1'b1;
         end
         pending_components.push_back(w);
      end
   endfunction

   function automatic void apply_word(req_type w);
      case (w.cmd)
         CMD_LOAD_MATRIX: begin
            matrix_mem[w.row*DIM_MAX+w.col] = w.value;
            matrix_set[w.row*DIM_MAX+w.col] = 1'b1;
         end
         CMD_LOAD_VECTOR: begin
            vector_mem[w.row] = w.value;
            vector_set[w.row] = 1'b1;
         end
         CMD_START: run_power_iteration();
         default: ;
      endcase
   endfunction

   task automatic report(string field, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", field, got, want);
      error_count++;
   endtask

   task automatic check_component(rsp_type got);
      rsp_type want;
      if (pending_components.size() == 0) begin
         report("unexpected word, index", got.index, -1);
      end else begin
         want = pending_components.pop_front();
         if (got.index !== want.index) report("index", got.index, want.index);
         if (got.component !== want.component)
            report("component", got.component, want.component);
         if (got.eigenvalue !== want.eigenvalue)
            report("eigenvalue", got.eigenvalue, want.eigenvalue);
         if (got.passes !== want.passes) report("passes", got.passes, want.passes);
         if (got.converged !== want.converged)
            report("converged", got.converged, want.converged);
         if (got.last !== want.last) report("last", got.last, want.last);
      end
   endtask

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [31:0] rand_value(fill_type k);
      case (k)
         FILL_FULL: return $urandom;
         FILL_ZERO: return 0;
         default:   return int'($urandom_range(0, 524288)) - 262144;  // within +-4.0
      endcase
   endfunction

   // send one word on req, update the shadow once it is taken
   task automatic send_word(req_type w);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      apply_word(w);
      items_sent++;
   endtask

   task automatic send_cmd(logic [1:0] cmd, int row, int col, logic signed [31:0] value);
      req_type w;
      w.cmd = cmd;
      w.row = row[3:0];
      w.col = col[3:0];
      w.value = value;
      send_word(w);
   endtask

   // make sure nothing unwritten is read, then start
   task automatic start_run(fill_type k);
      int d;
      d = eff_dim();
      for (int i = 0; i < d; i++) begin
         for (int j = 0; j < d; j++)
            if (!matrix_set[i*DIM_MAX+j]) send_cmd(CMD_LOAD_MATRIX, i, j, rand_value(k));
         if (!vector_set[i]) send_cmd(CMD_LOAD_VECTOR, i, 0, rand_value(k));
      end
      send_cmd(CMD_START, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
   endtask

   // drain all results, then give the block time to settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_components.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all three registers back to back, optionally poking the unused index
   task automatic configure(logic [15:0] dim, logic [15:0] tol, logic [15:0] lim,
                            bit poke_unused);
      logic [1:0]  idx [4];
      logic [15:0] val [4];
      int          n;
      idx[0] = CSR_DIMENSION;       val[0] = dim;
      idx[1] = CSR_TOLERANCE;       val[1] = tol;
      idx[2] = CSR_ITERATION_LIMIT; val[2] = lim;
      idx[3] = CSR_UNUSED;          val[3] = 16'($urandom);
      n = poke_unused ? 4 : 3;
      for (int k = 0; k < n; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_data  <= val[k];
         do @(posedge clock); while (!csr_ready);
         case (idx[k])
            CSR_DIMENSION:       cfg_dimension = val[k][4:0];
            CSR_TOLERANCE:       cfg_tolerance = val[k];
            CSR_ITERATION_LIMIT: cfg_limit = val[k];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // reset registers: diagonal 2.0 with a ones vector converges at once
   task automatic test_reset_defaults();
      quiet = 1'b0;
      send_cmd(CMD_LOAD_MATRIX, 0, 1, 32'sh7fff_ffff);
      send_cmd(CMD_LOAD_VECTOR, 0, 0, 32'sh8000_0000);
      send_cmd(CMD_UNUSED, 15, 15, 32'sh8000_0000);
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++)
            send_cmd(CMD_LOAD_MATRIX, i, j, (i == j) ? 2 * Q_ONE : 0);
         send_cmd(CMD_LOAD_VECTOR, i, 0, Q_ONE);
      end
      start_run(FILL_SMALL);
   endtask

   // dimension edges, negative eigenvalue, limit zero, zero product, ties
   task automatic test_corner_cases();
      wait_idle();
      // dimension zero acts as one; negative entry, largest vector value
      configure(16'd0, 16'd0, 16'd3, 1'b1);
      send_cmd(CMD_LOAD_MATRIX, 0, 0, -2 * Q_ONE);
      send_cmd(CMD_LOAD_VECTOR, 0, 0, 32'sh7fff_ffff);
      start_run(FILL_SMALL);
      // iteration limit zero just emits the stored vector
      wait_idle();
      configure(16'd2, 16'd1, 16'd0, 1'b0);
      start_run(FILL_SMALL);
      // zero matrix skips scaling
      wait_idle();
      configure(16'd2, 16'hffff, 16'd5, 1'b0);
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++) send_cmd(CMD_LOAD_MATRIX, i, j, 0);
      start_run(FILL_ZERO);
      // +1/-1 diagonal gives equal magnitudes and never settles
      wait_idle();
      configure(16'd2, 16'd1, 16'd5, 1'b0);
      send_cmd(CMD_LOAD_MATRIX, 0, 0, Q_ONE);
      send_cmd(CMD_LOAD_MATRIX, 1, 1, -Q_ONE);
      send_cmd(CMD_LOAD_VECTOR, 0, 0, Q_ONE);
      send_cmd(CMD_LOAD_VECTOR, 1, 0, Q_ONE);
      start_run(FILL_SMALL);
   endtask

   task automatic pick_config();
      int          r, t;
      logic [15:0] dim, tol, lim;
      r = $urandom_range(0, 19);
      dim = 16'($urandom);
      case (r)
         0: begin dim[4:0] = 5'd0; lim = 16'($urandom_range(1, 30)); end
         1: begin
            dim[4:0] = 5'($urandom_range(17, 31));
            lim = 16'($urandom_range(1, 2));
         end
         2: begin
            dim[4:0] = 5'($urandom_range(6, 10));
            lim = 16'($urandom_range(1, 4));
         end
         default: begin
            dim[4:0] = 5'($urandom_range(1, 5));
            lim = 16'($urandom_range(1, 25));
         end
      endcase
      t = $urandom_range(0, 9);
      if (t == 0) tol = '0;
      else if (t == 1) tol = 16'($urandom);
      else tol = 16'($urandom_range(1, 4096));
      configure(dim, tol, lim, 1'b0);
   endtask

   // well-formed runs with random content, plus stray and ignored words
   task automatic test_random_runs();
      int n, d, r;
      while (items_sent < ITEM_TARGET) begin
         quiet = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 1)) begin
            wait_idle();
            pick_config();
         end
         d = eff_dim();
         n = $urandom_range(0, 6);
         repeat (n) begin
            r = $urandom_range(0, 9);
            if (r < 4)
               send_cmd(CMD_LOAD_MATRIX, $urandom_range(0, d-1), $urandom_range(0, d-1),
                        rand_value(($urandom_range(0, 4) == 0) ? FILL_FULL : FILL_SMALL));
            else if (r < 7)
               send_cmd(CMD_LOAD_VECTOR, $urandom_range(0, d-1), $urandom, rand_value(FILL_SMALL));
            else if (r == 7)
               send_cmd(CMD_LOAD_MATRIX, $urandom, $urandom, $urandom);
            else if (r == 8)
               send_cmd(CMD_LOAD_VECTOR, $urandom, $urandom, $urandom);
            else
               send_cmd(CMD_UNUSED, $urandom, $urandom, $urandom);
         end
         start_run(($urandom_range(0, 4) == 0) ? FILL_FULL : FILL_SMALL);
      end
   endtask

   // receiver holds off while the sender keeps going, so the block backs up
   task automatic test_output_backpressure();
      wait_idle();
      configure(16'd3, 16'd64, 16'd4, 1'b0);
      quiet = 1'b1;
      hold_req = 1'b1;
      for (int i = 0; i < 3; i++) send_cmd(CMD_LOAD_VECTOR, i, 0, rand_value(FILL_SMALL));
      start_run(FILL_SMALL);
      for (int i = 0; i < 3; i++) send_cmd(CMD_LOAD_MATRIX, i, i, rand_value(FILL_SMALL));
      start_run(FILL_SMALL);
      quiet = 1'b0;
   endtask

   // receiver: checks every accepted word, then picks its next ready
   always @(posedge clock) begin : rsp_side
      int hold_left;
      int stall_left;
      int r;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) check_component(rsp_data);
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (quiet) begin
            rsp_ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
               rsp_ready <= 1'b1;
            end else begin
               stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
               rsp_ready <= 1'b0;
            end
         end
      end
   end

   // watchdog: too long with no word moving on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_DIMENSION;
      csr_data  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_corner_cases();
      test_random_runs();
      test_output_backpressure();

      // drain whatever is still on its way
      wait_idle();
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/pie_pkg.sv
hw/rtl/power_iteration_eigen.sv
hw/rtl/pie_checker.sv
bench/tb_power_iteration_eigen.sv
